FILE: hdl/deq_pkg.sv
// Package for the double-ended queue: command codes, status codes, control states and defaults.
// It depends on nothing. The cell, the ring and the top level import it.
`default_nettype none

package deq_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 64;
  localparam int WORD_W             = 64;
  localparam int CMD_W              = 3;
  localparam int STAT_W             = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5,
    CMD_CLEAR      = 3'd6,
    CMD_EXIT       = 3'd7
  } cmd_t;

  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_WORD    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_GOODBYE = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SEEK = 3'b010,
    ST_RESP = 3'b100
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/deq_cell.sv
// One storage cell of the circulating ring: it takes its neighbour's word every cycle,
// or a new word when loaded. It depends on deq_pkg for the default width.
`default_nettype none

module deq_cell
  import deq_pkg::*;
#(
  parameter int WIDTH = DATA_WIDTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic [WIDTH-1:0] load_word,
  input  wire logic [WIDTH-1:0] neighbour_word,
  output logic      [WIDTH-1:0] word
);

  always_ff @(posedge clk) begin
    word <= load ? load_word : neighbour_word;
  end

endmodule

`default_nettype wire

FILE: hdl/deq_ring.sv
// The ring of storage cells, rotating by one place every cycle, and the phase counter that
// names the slot now at the head cell. It depends on deq_pkg and deq_cell.
`default_nettype none

module deq_ring
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
  localparam int IDX_W     = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [DATA_WIDTH-1:0] wr_word,
  output logic      [DATA_WIDTH-1:0] head_word,
  output logic      [IDX_W-1:0]      phase
);

  logic [DATA_WIDTH-1:0] cell_word [DEPTH];

  // The head cell holds the slot named by phase; a write replaces it as it wraps round.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (phase == IDX_W'(DEPTH - 1)) begin
      phase <= '0;
    end else begin
      phase <= phase + 1'b1;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      deq_cell #(
        .WIDTH(DATA_WIDTH)
      ) u_cell (
        .clk           (clk),
        .load          (wr_en),
        .load_word     (wr_word),
        .neighbour_word(cell_word[0]),
        .word          (cell_word[i])
      );
    end else begin : g_body
      deq_cell #(
        .WIDTH(DATA_WIDTH)
      ) u_cell (
        .clk           (clk),
        .load          (1'b0),
        .load_word     (wr_word),
        .neighbour_word(cell_word[i+1]),
        .word          (cell_word[i])
      );
    end
  end

  assign head_word = cell_word[0];

endmodule

`default_nettype wire

FILE: hdl/double_ended_queue.sv
// Double-ended queue held in a circulating ring of DEPTH cells.
// Commands that do not touch storage give their result in the cycle after they are taken; pushes,
// pops and peeks wait in the seek state for the target slot to reach the head cell.
// Throughput: one item in flight; the next beat is taken once the result has been taken.
// Halted items are taken one a cycle and give no result.
// Reset clears the ends, the count, the halt flag and the control state; cell contents are kept.
`default_nettype none

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CMD_W-1:0]  cmd,
  input  wire logic [WORD_W-1:0] word_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [STAT_W-1:0] status,
  output logic      [WORD_W-1:0] word_out
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  state_t                state;
  logic [IDX_W-1:0]      front_index;
  logic [CNT_W-1:0]      entry_count;
  logic                  halted;
  logic [IDX_W-1:0]      target;
  logic                  do_write;
  logic [DATA_WIDTH-1:0] pending_word;
  logic [STAT_W-1:0]     resp_status;
  logic [DATA_WIDTH-1:0] resp_word;

  logic [DATA_WIDTH-1:0] head_word;
  logic [IDX_W-1:0]      phase;
  logic                  wr_en;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [IDX_W-1:0]      front_dec;
  logic [IDX_W-1:0]      front_inc;
  logic [SUM_W-1:0]      end_sum;
  logic [SUM_W-1:0]      last_sum;
  logic [IDX_W-1:0]      end_slot;
  logic [IDX_W-1:0]      last_slot;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_RESP);
  assign accept    = in_valid && in_ready;
  assign status    = resp_status;
  assign word_out  = WORD_W'(resp_word);

  assign full  = (entry_count == CNT_W'(DEPTH));
  assign empty = (entry_count == '0);

  assign front_dec = (front_index == '0) ? IDX_W'(DEPTH - 1) : front_index - 1'b1;
  assign front_inc = (front_index == IDX_W'(DEPTH - 1)) ? '0 : front_index + 1'b1;
  assign end_sum   = SUM_W'(front_index) + SUM_W'(entry_count);
  assign last_sum  = end_sum - 1'b1;
  assign end_slot  = (end_sum >= SUM_W'(DEPTH)) ? IDX_W'(end_sum - SUM_W'(DEPTH))
                                                : IDX_W'(end_sum);
  assign last_slot = (last_sum >= SUM_W'(DEPTH)) ? IDX_W'(last_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(last_sum);

  assign wr_en = (state == ST_SEEK) && (phase == target) && do_write;

  deq_ring #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_word  (pending_word),
    .head_word(head_word),
    .phase    (phase)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      pending_word <= word_in[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      front_index <= '0;
      entry_count <= '0;
      halted      <= 1'b0;
      target      <= '0;
      do_write    <= 1'b0;
      resp_status <= STAT_OK;
      resp_word   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && !halted) begin
            resp_word <= '0;
            case (cmd_t'(cmd))
              CMD_PUSH_FRONT: begin
                if (full) begin
                  resp_status <= STAT_FULL;
                  state       <= ST_RESP;
                end else begin
                  front_index <= front_dec;
                  entry_count <= entry_count + 1'b1;
                  target      <= front_dec;
                  do_write    <= 1'b1;
                  state       <= ST_SEEK;
                end
              end
              CMD_PUSH_BACK: begin
                if (full) begin
                  resp_status <= STAT_FULL;
                  state       <= ST_RESP;
                end else begin
                  entry_count <= entry_count + 1'b1;
                  target      <= end_slot;
                  do_write    <= 1'b1;
                  state       <= ST_SEEK;
                end
              end
              CMD_POP_FRONT, CMD_PEEK_FRONT: begin
                if (empty) begin
                  resp_status <= STAT_EMPTY;
                  state       <= ST_RESP;
                end else begin
                  if (cmd_t'(cmd) == CMD_POP_FRONT) begin
                    front_index <= front_inc;
                    entry_count <= entry_count - 1'b1;
                  end
                  target   <= front_index;
                  do_write <= 1'b0;
                  state    <= ST_SEEK;
                end
              end
              CMD_POP_BACK, CMD_PEEK_BACK: begin
                if (empty) begin
                  resp_status <= STAT_EMPTY;
                  state       <= ST_RESP;
                end else begin
                  if (cmd_t'(cmd) == CMD_POP_BACK) begin
                    entry_count <= entry_count - 1'b1;
                  end
                  target   <= last_slot;
                  do_write <= 1'b0;
                  state    <= ST_SEEK;
                end
              end
              CMD_CLEAR: begin
                entry_count <= '0;
                resp_status <= STAT_OK;
                state       <= ST_RESP;
              end
              CMD_EXIT: begin
                halted      <= 1'b1;
                resp_status <= STAT_GOODBYE;
                state       <= ST_RESP;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SEEK: begin
          if (phase == target) begin
            if (do_write) begin
              resp_status <= STAT_OK;
              resp_word   <= '0;
            end else begin
              resp_status <= STAT_WORD;
              resp_word   <= head_word;
            end
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(DEPTH))
    else $error("Entry count exceeds the ring depth.");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("Halt flag fell without a reset.");

  a_word_only_with_word_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STAT_WORD)) |-> (word_out == '0))
    else $error("A result without a returned word carries a non-zero word.");

  a_write_only_in_seek: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (state == ST_RESP) && (resp_status == STAT_OK))
    else $error("A ring write was not followed by an ok result.");
`endif

endmodule

`default_nettype wire

FILE: sim/double_ended_queue_checker.sv
// Checker for the double-ended queue: watches both channels, predicts each result beat
// from its own copy of the ring, and compares status and word. Depends on deq_pkg.
`timescale 1ns / 100ps

module double_ended_queue_checker
  import deq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [CMD_W-1:0]  cmd,
  input  wire logic [WORD_W-1:0] word_in,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic [STAT_W-1:0] status,
  input  wire logic [WORD_W-1:0] word_out,
  output int                     fails,
  output int                     left
);

  localparam int RING = DEPTH_DEFAULT;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] word;
  } deque_answer_t;

  logic [WORD_W-1:0] slots [RING];
  int                head;
  int                fill;
  bit                stopped;
  deque_answer_t     answers_due[$];
  deque_answer_t     want;

  task automatic count_fault(input string msg);
    fails = fails + 1;
    if (fails <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  task automatic apply_command(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] w);
    deque_answer_t a;
    a.status = STAT_OK;
    a.word   = '0;
    if (!stopped) begin
      case (op)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (fill >= RING) begin
            a.status = STAT_FULL;
          end else if (op == CMD_PUSH_FRONT) begin
            head        = (head + RING - 1) % RING;
            slots[head] = w;
            fill        = fill + 1;
          end else begin
            slots[(head + fill) % RING] = w;
            fill                        = fill + 1;
          end
        end
        CMD_POP_FRONT, CMD_PEEK_FRONT: begin
          if (fill == 0) begin
            a.status = STAT_EMPTY;
          end else begin
            a.status = STAT_WORD;
            a.word   = slots[head];
            if (op == CMD_POP_FRONT) begin
              head = (head + 1) % RING;
              fill = fill - 1;
            end
          end
        end
        CMD_POP_BACK, CMD_PEEK_BACK: begin
          if (fill == 0) begin
            a.status = STAT_EMPTY;
          end else begin
            a.status = STAT_WORD;
            a.word   = slots[(head + fill - 1) % RING];
            if (op == CMD_POP_BACK) begin
              fill = fill - 1;
            end
          end
        end
        CMD_CLEAR: begin
          fill = 0;
        end
        default: begin
          a.status = STAT_GOODBYE;
          stopped  = 1'b1;
        end
      endcase
      answers_due.insert(answers_due.size(), a);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head    = 0;
      fill    = 0;
      stopped = 1'b0;
      answers_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        apply_command(cmd, word_in);
      end
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          count_fault($sformatf("unexpected result beat: status %0d word %h",
                                status, word_out));
        end else begin
          want = answers_due[0];
          answers_due.delete(0);
          if (status !== want.status) begin
            count_fault($sformatf("status mismatch: expected %0d, got %0d",
                                  want.status, status));
          end
          if (word_out !== want.word) begin
            count_fault($sformatf("word mismatch: expected %h, got %h",
                                  want.word, word_out));
          end
        end
      end
    end
    left <= answers_due.size();
  end

endmodule

FILE: sim/double_ended_queue_tb.sv
// Top of the double-ended queue testbench: clock, reset, directed and random command
// beats with random idling on both sides, and the verdict. Depends on deq_pkg and the checker.
`timescale 1ns / 100ps

module double_ended_queue_tb;
  import deq_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  cmd = CMD_PUSH_FRONT;
  logic [WORD_W-1:0] word_in = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic [WORD_W-1:0] word_out;
  int                fails;
  int                left;

  bit send_calm;
  int sent;
  int phase;
  int lean;
  int span;
  int taken;
  int hold;
  bit take_calm;

  double_ended_queue dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .word_in   (word_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .word_out  (word_out)
  );

  double_ended_queue_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .word_in   (word_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .word_out  (word_out),
    .fails     (fails),
    .left      (left)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("double_ended_queue_tb NOT OK");
    $finish;
  end

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic cmd_t pick_command(input int bias);
    int r;
    int push_share;
    if ($urandom_range(0, 99) < 2) begin
      return CMD_CLEAR;
    end
    push_share = (bias == 0) ? 80 : (bias == 1) ? 20 : 50;
    r = $urandom_range(0, 99);
    if (r < push_share) begin
      return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end
    return cmd_t'($urandom_range(CMD_POP_FRONT, CMD_PEEK_BACK));
  endfunction

  // Entered and left at a falling edge.
  task automatic send_beat(input cmd_t c, input logic [WORD_W-1:0] w);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    word_in  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent = sent + 1;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (left != 0) @(negedge clk);
  endtask

  initial begin
    taken     = 0;
    take_calm = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    forever begin
      if (taken % 50 == 0) begin
        take_calm = ($urandom_range(0, 3) == 0);
      end
      // A long hold-off keeps a result waiting, so the block stalls the sender's input.
      if (taken == 300 || taken == 1100) begin
        hold = 80;
      end else begin
        hold = take_calm ? 0 : $urandom_range(0, 6);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
      taken = taken + 1;
    end
  end

  initial begin
    sent      = 0;
    send_calm = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_beat(CMD_POP_FRONT, '1);
    send_beat(CMD_POP_BACK, '0);
    send_beat(CMD_PEEK_FRONT, '1);
    send_beat(CMD_PEEK_BACK, '0);
    send_beat(CMD_PUSH_FRONT, '1);
    send_beat(CMD_PUSH_BACK, '0);
    send_beat(CMD_PEEK_FRONT, '0);
    send_beat(CMD_PEEK_BACK, '1);
    send_beat(CMD_POP_BACK, '1);
    send_beat(CMD_POP_FRONT, '0);
    send_beat(CMD_PUSH_BACK, 64'h8000_0000_0000_0001);
    send_beat(CMD_CLEAR, '1);
    send_beat(CMD_PEEK_BACK, '0);
    send_beat(CMD_POP_FRONT, '0);

    phase = 0;
    while (sent < 1790) begin
      lean      = (phase == 0) ? 0 : $urandom_range(0, 2);
      span      = $urandom_range(20, 80);
      send_calm = ($urandom_range(0, 3) == 0);
      if (phase == 10 || phase == 25) begin
        drain_results();
      end
      repeat (span) send_beat(pick_command(lean), pick_word());
      phase = phase + 1;
    end

    send_beat(CMD_EXIT, pick_word());
    repeat (3) send_beat(cmd_t'($urandom_range(CMD_PUSH_FRONT, CMD_EXIT)), pick_word());
    drain_results();
    repeat (24) @(negedge clk);
    if (fails == 0) begin
      $display("double_ended_queue_tb OK");
    end else begin
      $display("double_ended_queue_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: double_ended_queue.f
hdl/deq_pkg.sv
hdl/deq_cell.sv
hdl/deq_ring.sv
hdl/double_ended_queue.sv
sim/double_ended_queue_checker.sv
sim/double_ended_queue_tb.sv
